@@ design/smvs_pkg.sv @@
// Package for the serial memory verify sequencer.
// Holds field widths, command and phase codes and the beat payload structs.
// No dependencies; every other design file uses it.
package smvs_pkg;

  localparam int ADDR_W      = 17;
  localparam int COUNT_W     = 18;
  localparam int WORD_W      = 16;
  localparam int BYTE_W      = 8;
  localparam int RETRY_W     = 8;
  localparam int ADDR_BITS_DEF = 17;

  localparam logic [RETRY_W-1:0] RETRY_RESET = 8'd3;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_WREN  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [4:0] {
    PH_IDLE     = 5'b00001,
    PH_DISPATCH = 5'b00010,
    PH_READ     = 5'b00100,
    PH_WREN     = 5'b01000,
    PH_WRITE    = 5'b10000
  } phase_t;

  typedef struct packed {
    logic               req_type;
    logic               start_read;
    logic               start_write;
    logic [ADDR_W-1:0]  start_address;
    logic [COUNT_W-1:0] start_count;
    logic               buffer_present;
    logic [WORD_W-1:0]  word_in;
    logic [BYTE_W-1:0]  mem_byte;
  } in_item_t;

  typedef struct packed {
    cmd_t               command;
    logic [ADDR_W-1:0]  mem_address;
    logic [BYTE_W-1:0]  mem_data;
    logic               word_out_valid;
    logic [WORD_W-1:0]  word_out;
    logic               word_advance;
    logic               busy_res;
    logic               done_res;
    logic               error;
  } out_item_t;

endpackage

@@ design/smvs_if.sv @@
// Valid/ready channel interfaces for the sequencer's input, result and config beats.
// Depends on smvs_pkg for the payload types and widths.
interface smvs_in_if;
  logic               valid;
  logic               ready;
  smvs_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface smvs_out_if;
  logic                valid;
  logic                ready;
  smvs_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface smvs_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [smvs_pkg::RETRY_W-1:0]     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/serial_memory_verify_sequencer_core.sv @@
// Top level of the serial memory verify sequencer: input register, step logic, result register.
// Depends on smvs_pkg, smvs_if, smvs_in_stage, smvs_step and smvs_out_stage.
//
//   channel   direction  beat content
//   in_bus    sink       start request or tick, host word, memory byte
//   out_bus   source     command, address, data, read word, status flags
//   cfg_bus   sink       retry limit
//
// Each beat passes the input register, one step of logic and the result register;
// the core takes one beat per cycle when the output is not stalled.
// Reset is synchronous; it clears the state, both registers and sets the retry limit to 3.
// A stalled result holds in the result register while one more beat waits in the input register.
module serial_memory_verify_sequencer_core #(
  parameter int ADDR_BITS = smvs_pkg::ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  smvs_in_if.sink     in_bus,
  smvs_out_if.source  out_bus,
  smvs_cfg_if.sink    cfg_bus
);

  logic [smvs_pkg::RETRY_W-1:0] retry_limit_r;
  logic                         hold_valid;
  logic                         space;
  logic                         take;
  smvs_pkg::in_item_t           item;
  smvs_pkg::out_item_t          res;

  assign cfg_bus.ready = 1'b1;
  assign take          = hold_valid && space;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_limit_r <= smvs_pkg::RETRY_RESET;
    end else if (cfg_bus.valid && cfg_bus.ready) begin
      retry_limit_r <= cfg_bus.data;
    end
  end

  smvs_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .take       (take),
    .hold_valid (hold_valid),
    .item       (item)
  );

  smvs_step #(
    .ADDR_BITS (ADDR_BITS)
  ) u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (take),
    .item        (item),
    .retry_limit (retry_limit_r),
    .res         (res)
  );

  smvs_out_stage u_out_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (take),
    .res     (res),
    .space   (space),
    .out_bus (out_bus)
  );

endmodule

@@ design/smvs_in_stage.sv @@
// Input register of the sequencer: captures one input beat and holds it until taken.
// Depends on smvs_pkg and smvs_in_if.
module smvs_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  smvs_in_if.sink            in_bus,
  input  logic               take,
  output logic               hold_valid,
  output smvs_pkg::in_item_t item
);

  logic               valid_r;
  smvs_pkg::in_item_t item_r;

  assign in_bus.ready = !valid_r || take;
  assign hold_valid   = valid_r;
  assign item         = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_bus.valid && in_bus.ready) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      item_r <= in_bus.payload;
    end
  end

endmodule

@@ design/smvs_step.sv @@
// Sequencer state and the one-step next-state and result logic.
// Depends on smvs_pkg.
module smvs_step #(
  parameter int ADDR_BITS = smvs_pkg::ADDR_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step_en,
  input  smvs_pkg::in_item_t             item,
  input  logic [smvs_pkg::RETRY_W-1:0]   retry_limit,
  output smvs_pkg::out_item_t            res
);

  smvs_pkg::phase_t                phase_r, phase_nxt;
  logic                            want_read_r, want_read_nxt;
  logic                            want_write_r, want_write_nxt;
  logic [ADDR_BITS-1:0]            cur_addr_r, cur_addr_nxt;
  logic [smvs_pkg::COUNT_W-1:0]    remaining_r, remaining_nxt;
  logic [smvs_pkg::RETRY_W-1:0]    retry_count_r, retry_count_nxt;
  logic [smvs_pkg::WORD_W-1:0]     read_word_r, read_word_nxt;
  logic [smvs_pkg::BYTE_W-1:0]     write_byte_r, write_byte_nxt;
  logic                            has_buffer_r, has_buffer_nxt;
  logic                            error_r, error_nxt;

  always_comb begin
    logic                       busy;
    logic                       do_next;
    logic [smvs_pkg::RETRY_W:0] tries;
    phase_nxt       = phase_r;
    want_read_nxt   = want_read_r;
    want_write_nxt  = want_write_r;
    cur_addr_nxt    = cur_addr_r;
    remaining_nxt   = remaining_r;
    retry_count_nxt = retry_count_r;
    read_word_nxt   = read_word_r;
    write_byte_nxt  = write_byte_r;
    has_buffer_nxt  = has_buffer_r;
    error_nxt       = error_r;
    res             = '0;
    res.command     = smvs_pkg::CMD_NONE;
    busy            = want_read_r || want_write_r;
    do_next         = 1'b0;
    tries           = {1'b0, retry_count_r} + 1'b1;

    if (item.req_type) begin
      if (!busy && (item.start_read || item.start_write)) begin
        want_read_nxt  = item.start_read;
        want_write_nxt = !item.start_read;
        cur_addr_nxt   = ADDR_BITS'(item.start_address);
        remaining_nxt  = (item.start_count == '0) ? smvs_pkg::COUNT_W'(1) : item.start_count;
        has_buffer_nxt = item.buffer_present;
        phase_nxt      = smvs_pkg::PH_DISPATCH;
      end
    end else if (!busy) begin
      phase_nxt = smvs_pkg::PH_IDLE;
    end else begin
      case (phase_r)
        smvs_pkg::PH_READ: begin
          res.command     = smvs_pkg::CMD_READ;
          res.mem_address = smvs_pkg::ADDR_W'(cur_addr_r);
          if (!want_write_r) begin
            if (!cur_addr_r[0]) begin
              read_word_nxt = {8'h00, item.mem_byte};
            end else begin
              read_word_nxt      = {item.mem_byte, read_word_r[7:0]};
              res.word_out_valid = 1'b1;
              res.word_out       = read_word_nxt;
            end
            do_next = 1'b1;
          end else if (item.mem_byte != write_byte_r) begin
            retry_count_nxt = tries[smvs_pkg::RETRY_W-1:0];
            if (tries < {1'b0, retry_limit}) begin
              want_read_nxt = 1'b0;
            end else begin
              error_nxt      = 1'b1;
              want_read_nxt  = 1'b0;
              want_write_nxt = 1'b0;
              res.done_res   = 1'b1;
            end
          end else begin
            retry_count_nxt = '0;
            want_read_nxt   = 1'b0;
            do_next         = 1'b1;
          end
          if (do_next) begin
            if (remaining_r > smvs_pkg::COUNT_W'(1)) begin
              res.word_advance = has_buffer_r && cur_addr_r[0];
              cur_addr_nxt     = cur_addr_r + 1'b1;
              remaining_nxt    = remaining_r - 1'b1;
            end else begin
              retry_count_nxt = '0;
              remaining_nxt   = '0;
              want_read_nxt   = 1'b0;
              want_write_nxt  = 1'b0;
              res.done_res    = 1'b1;
            end
          end
          phase_nxt = (want_read_nxt || want_write_nxt) ? smvs_pkg::PH_DISPATCH
                                                        : smvs_pkg::PH_IDLE;
        end
        smvs_pkg::PH_WREN: begin
          res.command = smvs_pkg::CMD_WREN;
          if (!has_buffer_r) begin
            write_byte_nxt = '0;
          end else if (cur_addr_r[0]) begin
            write_byte_nxt = item.word_in[15:8];
          end else begin
            write_byte_nxt = item.word_in[7:0];
          end
          phase_nxt = smvs_pkg::PH_WRITE;
        end
        smvs_pkg::PH_WRITE: begin
          res.command     = smvs_pkg::CMD_WRITE;
          res.mem_address = smvs_pkg::ADDR_W'(cur_addr_r);
          res.mem_data    = write_byte_r;
          want_read_nxt   = 1'b1;
          phase_nxt       = smvs_pkg::PH_DISPATCH;
        end
        default: begin
          phase_nxt = want_read_r ? smvs_pkg::PH_READ : smvs_pkg::PH_WREN;
        end
      endcase
    end

    res.busy_res = want_read_nxt || want_write_nxt;
    res.error    = error_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= smvs_pkg::PH_IDLE;
      want_read_r   <= 1'b0;
      want_write_r  <= 1'b0;
      cur_addr_r    <= '0;
      remaining_r   <= '0;
      retry_count_r <= '0;
      read_word_r   <= '0;
      write_byte_r  <= '0;
      has_buffer_r  <= 1'b0;
      error_r       <= 1'b0;
    end else if (step_en) begin
      phase_r       <= phase_nxt;
      want_read_r   <= want_read_nxt;
      want_write_r  <= want_write_nxt;
      cur_addr_r    <= cur_addr_nxt;
      remaining_r   <= remaining_nxt;
      retry_count_r <= retry_count_nxt;
      read_word_r   <= read_word_nxt;
      write_byte_r  <= write_byte_nxt;
      has_buffer_r  <= has_buffer_nxt;
      error_r       <= error_nxt;
    end
  end

endmodule

@@ design/smvs_out_stage.sv @@
// Result register of the sequencer: holds one result beat until the sink takes it.
// Depends on smvs_pkg and smvs_out_if.
module smvs_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  smvs_pkg::out_item_t res,
  output logic                space,
  smvs_out_if.source          out_bus
);

  logic                valid_r;
  smvs_pkg::out_item_t res_r;

  assign space           = !valid_r || out_bus.ready;
  assign out_bus.valid   = valid_r;
  assign out_bus.payload = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule

@@ design/smvs_checker.sv @@
// Port-level checker for the sequencer core and the bind that attaches it.
// Depends on smvs_pkg and on the ports of serial_memory_verify_sequencer_core.
module smvs_port_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input smvs_pkg::out_item_t out_payload
);

  logic [1:0] pending_r;
  logic       err_seen_r;
  logic       in_fire;
  logic       out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r  <= '0;
      err_seen_r <= 1'b0;
    end else begin
      pending_r <= pending_r + {1'b0, in_fire} - {1'b0, out_fire};
      if (out_fire && out_payload.error) begin
        err_seen_r <= 1'b1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_payload))
    else $error("result beat changed while stalled");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 2'd0)
    else $error("result beat without a pending input beat");

  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && err_seen_r |-> out_payload.error)
    else $error("error flag cleared without reset");

  a_word_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.word_out_valid |-> out_payload.command == smvs_pkg::CMD_READ)
    else $error("read word delivered without a read command");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_payload.done_res |-> !out_payload.busy_res)
    else $error("done pulse while still busy");

endmodule

bind serial_memory_verify_sequencer_core smvs_port_checker u_smvs_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_bus.valid),
  .in_ready    (in_bus.ready),
  .out_valid   (out_bus.valid),
  .out_ready   (out_bus.ready),
  .out_payload (out_bus.payload)
);
